@@ rtl/core/nvcs_pkg.sv @@
// nvcs_pkg: sizes, codes and the scoring request type of the cosine search core
// no dependencies; imported by nvcs_score, nearest_vector_cosine_search_core and the bench
package nvcs_pkg;

  // vector store and field sizes
  localparam int MAX_DIM    = 1024;
  localparam int ADDR_BITS  = $clog2(MAX_DIM);
  localparam int LEN_BITS   = ADDR_BITS + 1;
  localparam int ELEM_BITS  = 16;
  localparam int INDEX_BITS = 16;
  localparam int SCORE_BITS = 16;
  localparam int NORM_BITS  = 42;
  localparam int DOT_BITS   = 43;

  // scoring unit sizes
  localparam int HALF_BITS = 22;                      // half operand; two halves cover DOT_BITS
  localparam int OP_BITS   = 2 * HALF_BITS;
  localparam int PP_BITS   = 2 * HALF_BITS;
  localparam int PROD_BITS = 2 * OP_BITS;
  localparam int MP_BITS   = PROD_BITS + SCORE_BITS;
  localparam int SUM_BITS  = 120;
  localparam int BIT_W     = $clog2(SCORE_BITS);
  localparam int RHS_SHIFT = 2 * (SCORE_BITS - 1);

  // item kinds
  localparam logic [1:0] K_TARGET = 2'd0;
  localparam logic [1:0] K_CAND   = 2'd1;
  localparam logic [1:0] K_END    = 2'd2;

  // score limits in q1.15
  localparam logic signed [SCORE_BITS-1:0] SCORE_NONE = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam logic signed [SCORE_BITS-1:0] SCORE_MAX  = {1'b0, {(SCORE_BITS-1){1'b1}}};

  typedef struct packed {
    logic [DOT_BITS-1:0]  dot;
    logic [NORM_BITS-1:0] tn;
    logic [NORM_BITS-1:0] cn;
  } score_req_t;

endpackage

@@ rtl/core/nvcs_score.sv @@
// nvcs_score: multi-cycle cosine scorer, dot / sqrt(tn * cn) as q1.15 by bit search
// depends on nvcs_pkg
module nvcs_score
  import nvcs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  score_req_t                   req,
  output logic                         done,
  output logic signed [SCORE_BITS-1:0] score
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MULP = 3'd1;
  localparam logic [2:0] PH_MULR = 3'd2;
  localparam logic [2:0] PH_TRY  = 3'd3;
  localparam logic [2:0] PH_TEST = 3'd4;

  logic [2:0]            phase;
  logic                  neg;
  logic [OP_BITS-1:0]    op_a;
  logic [OP_BITS-1:0]    op_b;
  logic [OP_BITS-1:0]    dm_r;
  logic [1:0]            pp_idx;
  logic [PROD_BITS-1:0]  prod_p;
  logic [PROD_BITS-1:0]  prod_r;
  logic [BIT_W-1:0]      bitpos;
  logic [SCORE_BITS-1:0] m;
  logic [SUM_BITS-1:0]   s;
  logic [SUM_BITS-1:0]   t;
  logic [MP_BITS-1:0]    mp;

  logic [DOT_BITS-1:0]   dot_mag;
  logic [HALF_BITS-1:0]  half_a;
  logic [HALF_BITS-1:0]  half_b;
  logic [PP_BITS-1:0]    pp;
  logic [PROD_BITS-1:0]  pp_sh;
  logic [PROD_BITS-1:0]  acc_sum;
  logic [SUM_BITS-1:0]   try_sum;
  logic [SUM_BITS-1:0]   test_sum;
  logic [SUM_BITS-1:0]   rhs;
  logic                  fits;
  logic [SCORE_BITS-1:0] m_new;
  logic                  last_step;
  logic signed [SCORE_BITS-1:0] score_val;

  assign dot_mag = req.dot[DOT_BITS-1] ? (~req.dot) + DOT_BITS'(1) : req.dot;

  // one half-width partial product per cycle
  assign half_a = pp_idx[1] ? op_a[OP_BITS-1:HALF_BITS] : op_a[HALF_BITS-1:0];
  assign half_b = pp_idx[0] ? op_b[OP_BITS-1:HALF_BITS] : op_b[HALF_BITS-1:0];
  assign pp     = half_a * half_b;

  always_comb begin
    pp_sh = PROD_BITS'(pp);
    if (pp_idx[1]) pp_sh = pp_sh << HALF_BITS;
    if (pp_idx[0]) pp_sh = pp_sh << HALF_BITS;
  end

  assign acc_sum = ((phase == PH_MULP) ? prod_p : prod_r) + pp_sh;

  // (m + 2^b)^2 * p = s + (m*p << (b+1)) + (p << 2b), one add per cycle
  assign try_sum  = s + (SUM_BITS'(mp) << ({1'b0, bitpos} + (BIT_W+1)'(1)));
  assign test_sum = t + (SUM_BITS'(prod_p) << {bitpos, 1'b0});
  assign rhs      = SUM_BITS'(prod_r) << RHS_SHIFT;
  assign fits     = test_sum <= rhs;
  assign m_new    = fits ? (m | (SCORE_BITS'(1) << bitpos)) : m;
  // a full-scale magnitude ends the search
  assign last_step = (bitpos == '0) || (fits && (bitpos == BIT_W'(SCORE_BITS - 1)));

  always_comb begin
    if (neg) begin
      score_val = $signed((~m_new) + SCORE_BITS'(1));
    end else if (m_new[SCORE_BITS-1]) begin
      score_val = SCORE_MAX;
    end else begin
      score_val = $signed(m_new);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            neg    <= req.dot[DOT_BITS-1];
            op_a   <= OP_BITS'(req.tn);
            op_b   <= OP_BITS'(req.cn);
            dm_r   <= OP_BITS'(dot_mag);
            prod_p <= '0;
            prod_r <= '0;
            pp_idx <= '0;
            phase  <= PH_MULP;
          end
        end
        PH_MULP: begin
          prod_p <= acc_sum;
          pp_idx <= pp_idx + 2'd1;
          if (pp_idx == 2'd3) begin
            op_a  <= dm_r;
            op_b  <= dm_r;
            phase <= PH_MULR;
          end
        end
        PH_MULR: begin
          prod_r <= acc_sum;
          pp_idx <= pp_idx + 2'd1;
          if (pp_idx == 2'd3) begin
            bitpos <= BIT_W'(SCORE_BITS - 1);
            m      <= '0;
            s      <= '0;
            mp     <= '0;
            phase  <= PH_TRY;
          end
        end
        PH_TRY: begin
          t     <= try_sum;
          phase <= PH_TEST;
        end
        PH_TEST: begin
          if (fits) begin
            s  <= test_sum;
            mp <= mp + (MP_BITS'(prod_p) << bitpos);
            m  <= m_new;
          end
          if (last_step) begin
            done  <= 1'b1;
            score <= score_val;
            phase <= PH_IDLE;
          end else begin
            bitpos <= bitpos - BIT_W'(1);
            phase  <= PH_TRY;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/nearest_vector_cosine_search_core.sv @@
// nearest_vector_cosine_search_core: top level of the cosine nearest-vector search
// depends on nvcs_pkg and nvcs_score
//
// A target vector is loaded one element per transaction (kind target) into a
// 1024-entry store; candidate elements (kind candidate) then stream against it,
// building the dot product and the candidate's squared norm. On a candidate's
// last element the candidate is scored as dot / sqrt(|t|^2 * |c|^2) in q1.15,
// truncated toward zero, with 1.0 saturating to 32767; the first strictly
// better score wins, starting from -32768 at index 0. A candidate whose length
// differs from the target scores 0; a candidate with a zero norm on either side
// is skipped but still takes an index. An end-of-list transaction produces one
// result (best_index, best_score, length_overflow) and restarts the search,
// keeping the target. Elements beyond 1024 are dropped and set length_overflow
// until reset. A transaction is taken when start is high and busy low; each
// element is accepted, with a store read, then worked on in the execute state.
// The last element of a candidate adds a close state; a scored one then waits
// for the scorer: the 22x22 partial products of tn * cn and of dot^2, a try and
// a test step per score bit for up to 16 bits (the search stops after the first
// bit when the magnitude is full scale), and a registered done for the score.
// The result appears on the cycle after the end-of-list transaction's work
// cycle, with done high for that single cycle; there is no way to hold it off,
// so the receiver must take it then. No clearing pass after reset: store data
// is only used below the loaded target length.
module nearest_vector_cosine_search_core
  import nvcs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind,
  input  logic signed [ELEM_BITS-1:0]  value,
  input  logic                         last_of_vector,
  output logic                         done,
  output logic [INDEX_BITS-1:0]        best_index,
  output logic signed [SCORE_BITS-1:0] best_score,
  output logic                         length_overflow
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CLOSE = 2'd2;
  localparam logic [1:0] ST_SCORE = 2'd3;

  // control and search state
  logic [1:0]                   state;
  logic [LEN_BITS-1:0]          target_length;
  logic [NORM_BITS-1:0]         target_norm_sq;
  logic [DOT_BITS-1:0]          dot_accum;
  logic [NORM_BITS-1:0]         cand_norm_sq;
  logic [LEN_BITS-1:0]          element_count;
  logic [INDEX_BITS-1:0]        cand_position;
  logic [INDEX_BITS-1:0]        best_pos;
  logic signed [SCORE_BITS-1:0] best_value;
  logic                         overflow_seen;
  logic                         loading_target;

  // captured transaction and target store
  logic [1:0]                   it_kind;
  logic signed [ELEM_BITS-1:0]  it_value;
  logic                         it_last;
  logic [ELEM_BITS-1:0]         tstore [MAX_DIM];
  logic [ELEM_BITS-1:0]         rd_data;

  logic                         accept;
  logic [LEN_BITS-1:0]          len_eff;
  logic [NORM_BITS-1:0]         norm_eff;
  logic                         tgt_room;
  logic                         cand_room;
  logic                         cand_paired;
  logic signed [2*ELEM_BITS-1:0] v_sq;
  logic signed [2*ELEM_BITS-1:0] v_t;
  logic                         wr_en;
  logic [ADDR_BITS-1:0]         wr_addr;
  logic                         len_mismatch;
  logic                         norm_zero;
  logic                         score_start;
  score_req_t                   score_req;
  logic                         score_done;
  logic signed [SCORE_BITS-1:0] score_val;
  logic                         cmp_en;
  logic signed [SCORE_BITS-1:0] cmp_score;
  logic                         cand_close;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // a target element after a finished target starts a fresh one
  assign len_eff  = loading_target ? target_length : '0;
  assign norm_eff = loading_target ? target_norm_sq : '0;
  assign tgt_room = len_eff < LEN_BITS'(MAX_DIM);

  assign cand_room   = element_count < LEN_BITS'(MAX_DIM);
  assign cand_paired = element_count < target_length;

  // element products, store data is the registered read issued at accept
  assign v_sq = it_value * it_value;
  assign v_t  = it_value * $signed(rd_data);

  assign wr_en   = (state == ST_EXEC) && (it_kind == K_TARGET) && tgt_room;
  assign wr_addr = len_eff[ADDR_BITS-1:0];

  // candidate close-out decisions
  assign len_mismatch = element_count != target_length;
  assign norm_zero    = (target_norm_sq == '0) || (cand_norm_sq == '0);
  assign score_start  = (state == ST_CLOSE) && !len_mismatch && !norm_zero;
  assign score_req    = '{dot: dot_accum, tn: target_norm_sq, cn: cand_norm_sq};

  nvcs_score u_score (
    .clk   (clk),
    .rst   (rst),
    .start (score_start),
    .req   (score_req),
    .done  (score_done),
    .score (score_val)
  );

  // mismatched lengths compare with score 0; skipped candidates only advance
  assign cmp_en     = ((state == ST_CLOSE) && len_mismatch) ||
                      ((state == ST_SCORE) && score_done);
  assign cmp_score  = (state == ST_SCORE) ? score_val : '0;
  assign cand_close = ((state == ST_CLOSE) && (len_mismatch || norm_zero)) ||
                      ((state == ST_SCORE) && score_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      target_length  <= '0;
      target_norm_sq <= '0;
      dot_accum      <= '0;
      cand_norm_sq   <= '0;
      element_count  <= '0;
      cand_position  <= '0;
      best_pos       <= '0;
      best_value     <= SCORE_NONE;
      overflow_seen  <= 1'b0;
      loading_target <= 1'b1;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          unique case (it_kind)
            K_TARGET: begin
              if (!loading_target) begin
                // new target drops any partial candidate
                dot_accum     <= '0;
                cand_norm_sq  <= '0;
                element_count <= '0;
              end
              if (tgt_room) begin
                target_norm_sq <= norm_eff + NORM_BITS'($unsigned(v_sq));
                target_length  <= len_eff + LEN_BITS'(1);
              end else begin
                overflow_seen <= 1'b1;
                target_length <= LEN_BITS'(MAX_DIM + 1);
              end
              loading_target <= !it_last;
            end
            K_CAND: begin
              loading_target <= 1'b0;
              if (cand_room) begin
                if (cand_paired) dot_accum <= dot_accum + DOT_BITS'(v_t);
                cand_norm_sq  <= cand_norm_sq + NORM_BITS'($unsigned(v_sq));
                element_count <= element_count + LEN_BITS'(1);
              end else begin
                overflow_seen <= 1'b1;
                element_count <= LEN_BITS'(MAX_DIM + 1);
              end
              if (it_last) state <= ST_CLOSE;
            end
            K_END: begin
              // result goes out next cycle, search restarts, target stays
              loading_target <= 1'b0;
              done           <= 1'b1;
              dot_accum      <= '0;
              cand_norm_sq   <= '0;
              element_count  <= '0;
              cand_position  <= '0;
              best_pos       <= '0;
              best_value     <= SCORE_NONE;
            end
            default: ;
          endcase
        end
        ST_CLOSE: begin
          // scorer has latched its operands by the next edge
          dot_accum     <= '0;
          cand_norm_sq  <= '0;
          element_count <= '0;
          state         <= score_start ? ST_SCORE : ST_IDLE;
        end
        ST_SCORE: begin
          if (score_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase

      if (cmp_en && (cmp_score > best_value)) begin
        best_value <= cmp_score;
        best_pos   <= cand_position;
      end
      if (cand_close) cand_position <= cand_position + INDEX_BITS'(1);
    end
  end

  // store port and payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      it_kind  <= kind;
      it_value <= value;
      it_last  <= last_of_vector;
      rd_data  <= tstore[element_count[ADDR_BITS-1:0]];
    end
    if (wr_en) tstore[wr_addr] <= it_value;
    if ((state == ST_EXEC) && (it_kind == K_END)) begin
      best_index      <= best_pos;
      best_score      <= best_value;
      length_overflow <= overflow_seen;
    end
  end

  // a result only follows the work cycle of an end-of-list transaction
  a_done_after_end: assert property (@(posedge clk) disable iff (rst)
    done |-> $past((state == ST_EXEC) && (it_kind == K_END)))
    else $error("result strobe without end-of-list work cycle");

  // an accepted transaction is worked on in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_EXEC))
    else $error("accepted transaction not executed");

  // the scorer only finishes while the core waits for it
  a_score_wait: assert property (@(posedge clk) disable iff (rst)
    score_done |-> (state == ST_SCORE))
    else $error("score returned outside score wait");

  // length counters saturate just past the store depth
  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    (element_count <= LEN_BITS'(MAX_DIM + 1)) && (target_length <= LEN_BITS'(MAX_DIM + 1)))
    else $error("length counter beyond saturation");

endmodule

@@ tb/sv/nearest_vector_cosine_search_core_tb.sv @@
`timescale 1ns / 100ps
// nearest_vector_cosine_search_core_tb: self-checking bench for the cosine nearest-vector search
// depends on nvcs_pkg and nearest_vector_cosine_search_core; predicts every best-match report
// from a bit-true search model kept in the bench and compares it field by field
module nearest_vector_cosine_search_core_tb;
  import nvcs_pkg::*;

  // kind code that the core must ignore
  localparam logic [1:0] K_UNUSED = 2'd3;
  // quiet cycles after the last report, well past the scoring latency
  localparam int DRAIN_CYCLES = 64;
  localparam int REPORT_LIMIT = 10;
  localparam int Q15_ONE = 1 << (SCORE_BITS - 1);

  typedef struct {
    logic [INDEX_BITS-1:0]        index;
    logic signed [SCORE_BITS-1:0] score;
    logic                         overflow;
  } best_match_t;

  typedef struct {
    logic [1:0]                  kind;
    logic signed [ELEM_BITS-1:0] value;
    logic                        last;
    bit                          typed;   // report value typed in below
    best_match_t                 want;
  } stim_row_t;

  // how candidate or target elements are filled
  typedef enum int {V_RANDOM, V_COPY, V_NEGATE, V_ZERO, V_NEAR, V_SMALL} fill_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [1:0]                   kind;
  logic signed [ELEM_BITS-1:0]  value;
  logic                         last_of_vector;
  logic                         done;
  logic [INDEX_BITS-1:0]        best_index;
  logic signed [SCORE_BITS-1:0] best_score;
  logic                         length_overflow;

  // search model state
  logic signed [ELEM_BITS-1:0]  stored_target [0:MAX_DIM-1];
  int                           stored_len;
  logic [NORM_BITS-1:0]         stored_norm;
  logic [DOT_BITS-1:0]          dot_sum;
  logic [NORM_BITS-1:0]         cand_energy;
  int                           cand_len;
  logic [INDEX_BITS-1:0]        cand_index;
  logic [INDEX_BITS-1:0]        lead_index;
  logic signed [SCORE_BITS-1:0] lead_score;
  bit                           overflow_flag;
  bit                           target_open;

  // best-match reports still owed by the core, oldest first
  best_match_t                  pending_best [$];
  // stimulus side copy of the current target, used to build look-alike candidates
  logic signed [ELEM_BITS-1:0]  shadow_target [$];
  stim_row_t                    directed_rows [$];
  best_match_t                  got;
  best_match_t                  want;
  int                           mismatches;
  int                           items_sent;
  int                           idle_pct;

  nearest_vector_cosine_search_core u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .kind            (kind),
    .value           (value),
    .last_of_vector  (last_of_vector),
    .done            (done),
    .best_index      (best_index),
    .best_score      (best_score),
    .length_overflow (length_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // exact q1.15 cosine: largest m with m^2 * tn * cn <= 2^30 * dot^2, capped at 1.0
  function automatic logic signed [SCORE_BITS-1:0] similarity_q15(
    input logic [DOT_BITS-1:0]  dot,
    input logic [NORM_BITS-1:0] tn,
    input logic [NORM_BITS-1:0] cn
  );
    logic [DOT_BITS-1:0] mag;
    logic [127:0]        lhs;
    logic [127:0]        rhs;
    int                  lo;
    int                  hi;
    int                  mid;
    mag = dot[DOT_BITS-1] ? (~dot + 1'b1) : dot;
    rhs = ({85'd0, mag} * {85'd0, mag}) << 30;
    lo = 0;
    hi = Q15_ONE;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 128'(mid) * 128'(mid) * {86'd0, tn} * {86'd0, cn};
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    // negative side keeps the full -1.0, positive side saturates
    if (dot[DOT_BITS-1]) return SCORE_BITS'(-lo);
    return (lo > Q15_ONE - 1) ? SCORE_MAX : SCORE_BITS'(lo);
  endfunction

  function automatic void drop_candidate();
    dot_sum = '0;
    cand_energy = '0;
    cand_len = 0;
  endfunction

  function automatic void restart_search();
    drop_candidate();
    cand_index = '0;
    lead_index = '0;
    lead_score = SCORE_NONE;
  endfunction

  // advance the search model by one accepted transaction
  function automatic void search_step(
    input logic [1:0]                  k,
    input logic signed [ELEM_BITS-1:0] v,
    input logic                        lst,
    output bit                         emits,
    output best_match_t                res
  );
    logic signed [SCORE_BITS-1:0] score;
    bit                           compare;
    emits = 1'b0;
    res = '{default: '0};
    case (k)
      K_TARGET: begin
        // a target element after candidates starts a fresh target
        if (!target_open) begin
          stored_len = 0;
          stored_norm = '0;
          drop_candidate();
          target_open = 1'b1;
        end
        if (stored_len < MAX_DIM) begin
          stored_target[stored_len] = v;
          stored_norm = stored_norm + NORM_BITS'(longint'(v) * longint'(v));
          stored_len++;
        end else begin
          overflow_flag = 1'b1;
          stored_len = MAX_DIM + 1;
        end
        if (lst) target_open = 1'b0;
      end
      K_CAND: begin
        target_open = 1'b0;
        if (cand_len < MAX_DIM) begin
          // store is only read below the loaded length
          if (cand_len < stored_len)
            dot_sum = dot_sum + DOT_BITS'(longint'(v) * longint'(stored_target[cand_len]));
          cand_energy = cand_energy + NORM_BITS'(longint'(v) * longint'(v));
          cand_len++;
        end else begin
          overflow_flag = 1'b1;
          cand_len = MAX_DIM + 1;
        end
        if (lst) begin
          compare = 1'b1;
          score = '0;
          if (cand_len != stored_len) score = '0;
          else if (stored_norm == 0 || cand_energy == 0) compare = 1'b0;
          else score = similarity_q15(dot_sum, stored_norm, cand_energy);
          if (compare && score > lead_score) begin
            lead_score = score;
            lead_index = cand_index;
          end
          cand_index = cand_index + 1'b1;
          drop_candidate();
        end
      end
      K_END: begin
        target_open = 1'b0;
        emits = 1'b1;
        res.index = lead_index;
        res.score = lead_score;
        res.overflow = overflow_flag;
        restart_search();
      end
      default: ;
    endcase
  endfunction

  function automatic stim_row_t dir_row(
    input logic [1:0]                   k,
    input logic signed [ELEM_BITS-1:0]  v,
    input logic                         lst,
    input bit                           typed = 1'b0,
    input logic [INDEX_BITS-1:0]        idx = '0,
    input logic signed [SCORE_BITS-1:0] sc = '0,
    input logic                         ov = 1'b0
  );
    stim_row_t r;
    r.kind = k;
    r.value = v;
    r.last = lst;
    r.typed = typed;
    r.want.index = idx;
    r.want.score = sc;
    r.want.overflow = ov;
    return r;
  endfunction

  function automatic logic signed [ELEM_BITS-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
      4, 5: return ELEM_BITS'($urandom_range(0, 200)) - 16'sd100;
      default: return ELEM_BITS'($urandom);
    endcase
  endfunction

  // one transaction: optional idle burst, then hold start until the core takes it
  task automatic send(
    input logic [1:0]                  k,
    input logic signed [ELEM_BITS-1:0] v,
    input logic                        lst
  );
    bit          emits;
    best_match_t res;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    value <= v;
    last_of_vector <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge
    search_step(k, v, lst, emits, res);
    if (emits) pending_best.push_back(res);
    items_sent++;
  endtask

  task automatic send_vector(
    input logic [1:0] k,
    input int         n,
    input fill_t      fill,
    input bit         close
  );
    logic signed [ELEM_BITS-1:0] v;
    logic signed [ELEM_BITS-1:0] src;
    if (k == K_TARGET) shadow_target.delete();
    for (int i = 0; i < n; i++) begin
      src = (k != K_TARGET && i < shadow_target.size()) ? shadow_target[i] : rand_elem();
      case (fill)
        V_COPY:   v = src;
        V_NEGATE: v = -src;
        V_ZERO:   v = '0;
        V_NEAR:   v = src + ELEM_BITS'($urandom_range(0, 6)) - 16'sd3;
        V_SMALL:  v = ELEM_BITS'($urandom_range(0, 16)) - 16'sd8;
        default:  v = rand_elem();
      endcase
      if (k == K_TARGET) shadow_target.push_back(v);
      send(k, v, close && (i == n - 1));
    end
  endtask

  // well-formed searches with random content, plus noise and broken sequences
  task automatic run_searches(input int goal, input bit idle_ok);
    int    tlen;
    int    clen;
    int    stop_at;
    fill_t fill;
    stop_at = items_sent + goal;
    while (items_sent < stop_at) begin
      // some searches run with no idling at all
      idle_pct = (!idle_ok || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
      if (shadow_target.size() == 0 || $urandom_range(0, 2) == 0) begin
        tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        // now and then the target is left unfinished
        send_vector(K_TARGET, tlen, ($urandom_range(0, 5) == 0) ? V_SMALL : V_RANDOM,
                    $urandom_range(0, 9) != 0);
      end
      tlen = shadow_target.size();
      repeat ($urandom_range(0, 6)) begin
        clen = tlen;
        case ($urandom_range(0, 9))
          4: fill = V_COPY;
          5: fill = V_NEGATE;
          6: fill = V_ZERO;
          7: begin
            fill = V_RANDOM;
            clen = $urandom_range(1, tlen + 2);
          end
          8: fill = V_NEAR;
          9: fill = V_SMALL;
          default: fill = V_RANDOM;
        endcase
        send_vector(K_CAND, clen, fill, 1'b1);
        if ($urandom_range(0, 19) == 0) send(K_UNUSED, ELEM_BITS'($urandom), 1'($urandom));
      end
      // partial candidate left open at the end of the list
      if ($urandom_range(0, 5) == 0) send_vector(K_CAND, $urandom_range(1, tlen), V_RANDOM, 1'b0);
      if ($urandom_range(0, 11) != 0) send(K_END, ELEM_BITS'($urandom), 1'($urandom));
    end
  endtask

  // report checker: the core cannot hold results, so every strobe is taken
  always @(posedge clk) begin
    if (!rst && done) begin
      got.index = best_index;
      got.score = best_score;
      got.overflow = length_overflow;
      if (pending_best.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected report index %0d score %0d overflow %0b",
                   $realtime, got.index, got.score, got.overflow);
      end else begin
        want = pending_best.pop_front();
        if (got.index !== want.index || got.score !== want.score ||
            got.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: expected index/score/ovf %0d/%0d/%0b, got %0d/%0d/%0b",
                     $realtime, want.index, want.score, want.overflow,
                     got.index, got.score, got.overflow);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = K_TARGET;
    value = '0;
    last_of_vector = 1'b0;
    mismatches = 0;
    items_sent = 0;
    idle_pct = 0;
    stored_len = 0;
    stored_norm = '0;
    overflow_flag = 1'b0;
    target_open = 1'b1;
    restart_search();

    // directed part: extremes and each special case of the search
    directed_rows.push_back(dir_row(K_END, 0, 1'b0, 1'b1, 0, SCORE_NONE, 1'b0));   // nothing loaded
    directed_rows.push_back(dir_row(K_UNUSED, 16'sh5a5a, 1'b1));                 // ignored kind
    directed_rows.push_back(dir_row(K_TARGET, 32767, 1'b1));
    directed_rows.push_back(dir_row(K_CAND, -32768, 1'b1));                     // exactly -1.0
    directed_rows.push_back(dir_row(K_CAND, 32767, 1'b1));                      // 1.0 saturates
    directed_rows.push_back(dir_row(K_END, -1, 1'b1, 1'b1, 1, SCORE_MAX, 1'b0));
    directed_rows.push_back(dir_row(K_TARGET, 100, 1'b0));
    directed_rows.push_back(dir_row(K_TARGET, -200, 1'b0));                     // left open
    directed_rows.push_back(dir_row(K_CAND, 3, 1'b0));                          // closes target
    directed_rows.push_back(dir_row(K_CAND, 4, 1'b1));
    directed_rows.push_back(dir_row(K_CAND, 5, 1'b1));                          // length differs
    directed_rows.push_back(dir_row(K_CAND, 0, 1'b0));
    directed_rows.push_back(dir_row(K_CAND, 0, 1'b1));                          // zero norm, skipped
    directed_rows.push_back(dir_row(K_CAND, 7, 1'b0));
    directed_rows.push_back(dir_row(K_TARGET, -1, 1'b1));                       // new target
    directed_rows.push_back(dir_row(K_CAND, 1, 1'b0));                          // partial at end
    directed_rows.push_back(dir_row(K_END, 0, 1'b0));
    directed_rows.push_back(dir_row(K_CAND, -32768, 1'b1));
    directed_rows.push_back(dir_row(K_END, 0, 1'b0, 1'b1, 0, SCORE_MAX, 1'b0));
    directed_rows.push_back(dir_row(K_END, 0, 1'b0, 1'b1, 0, SCORE_NONE, 1'b0)); // empty list
    directed_rows.push_back(dir_row(K_TARGET, 0, 1'b1));                        // zero target
    directed_rows.push_back(dir_row(K_CAND, 5, 1'b1));
    directed_rows.push_back(dir_row(K_END, 0, 1'b0, 1'b1, 0, SCORE_NONE, 1'b0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 30;
    foreach (directed_rows[i]) begin
      send(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].last);
      if (directed_rows[i].typed) pending_best[pending_best.size() - 1] = directed_rows[i].want;
    end

    run_searches(450, 1'b1);

    run_searches(250, 1'b1);

    // closing stretch with no idling
    run_searches(150, 1'b0);
    start <= 1'b0;

    while (pending_best.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/nvcs_pkg.sv
rtl/core/nvcs_score.sv
rtl/core/nearest_vector_cosine_search_core.sv
tb/sv/nearest_vector_cosine_search_core_tb.sv
